### src/ftlb_pkg.sv
// ----------------------------------------------------------------------------
// ftlb_pkg
// Shared constants for the FIFO-replacement translation lookaside buffer.
// ----------------------------------------------------------------------------
package ftlb_pkg;

    localparam int DEF_TLB_ENTRIES = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    localparam int ADDR_W  = 32;
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 32;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic hit;
        logic [FRAME_W-1:0] frame;
    } t_cam_rsp;

endpackage

### src/ftlb_cam.sv
// ----------------------------------------------------------------------------
// ftlb_cam
// Entry storage with a parallel page compare; insert drops older duplicates.
// ----------------------------------------------------------------------------
module ftlb_cam
    import ftlb_pkg::*;
#(
    parameter int ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGE_W  = 20,
    parameter int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PAGE_W-1:0] i_page,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_slot,
    output t_cam_rsp          o_rsp
);

    logic [ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]  r_page  [ENTRIES];
    logic [FRAME_W-1:0] r_frame [ENTRIES];
    logic [ENTRIES-1:0] match;

    always_comb begin
        o_rsp.frame = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_page[i] == i_page);
            o_rsp.frame = o_rsp.frame | (match[i] ? r_frame[i] : '0);
        end
        o_rsp.hit = |match;
    end

    // only the newest copy of a page can ever win, so older copies drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_wr_slot == SLOT_W'(i)) begin
                    r_valid[i] <= 1'b1;
                end else if (match[i]) begin
                    r_valid[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_wr_en && (i_wr_slot == SLOT_W'(i))) begin
                r_page[i]  <= i_page;
                r_frame[i] <= i_frame;
            end
        end
    end

endmodule

### src/fifo_translation_lookaside_buffer.sv
// ----------------------------------------------------------------------------
// fifo_translation_lookaside_buffer
// Fully associative TLB with FIFO replacement and saturating counters.
// ----------------------------------------------------------------------------
// One request is taken per cycle unless the result side stalls; its result
// passes the input register, then the result register. The rate is set by the
// combinational compare of the page number against every entry, with insert
// and lookup sharing that compare. Entry contents need no clearing pass: only
// the valid bits are reset, so the block accepts requests right after reset.
module fifo_translation_lookaside_buffer
    import ftlb_pkg::*;
#(
    parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // virt_addr[31:0], phys_frame[51:32], zero pad
    input  logic [0:0]  i_s_tuser,   // mode[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // phys_addr[31:0], lookup_count[63:32], miss_count[95:64]
    output logic [0:0]  o_m_tuser    // hit[0]
);

    localparam int OFFSET_BITS = $clog2(PAGE_BYTES + 1) - 1;
    localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
    localparam int SLOT_W      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FILL_W      = $clog2(TLB_ENTRIES + 1);

    logic               r_in_v;
    logic               r_in_mode;
    logic [ADDR_W-1:0]  r_in_va;
    logic [FRAME_W-1:0] r_in_frame;

    logic [FILL_W-1:0]  r_fill;
    logic [SLOT_W-1:0]  r_oldest;
    logic [CNT_W-1:0]   r_lookups;
    logic [CNT_W-1:0]   r_misses;

    logic               r_out_v;
    logic               r_out_hit;
    logic [ADDR_W-1:0]  r_out_pa;
    logic [CNT_W-1:0]   r_out_lc;
    logic [CNT_W-1:0]   r_out_mc;

    logic               advance;
    logic               full;
    logic               ins;
    logic               look;
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  page;
    logic [ADDR_W+FRAME_W-1:0] frame_wide;
    logic [ADDR_W-1:0]  n_pa;
    logic [CNT_W-1:0]   n_lookups;
    logic [CNT_W-1:0]   n_misses;
    t_cam_rsp           cam_rsp;

    assign advance    = r_in_v && (!r_out_v || i_m_tready);
    assign o_s_tready = !r_in_v || advance;
    assign full       = (r_fill == FILL_W'(TLB_ENTRIES));
    assign ins        = advance && (r_in_mode == MODE_INSERT);
    assign look       = advance && (r_in_mode == MODE_LOOKUP);
    assign slot       = full ? r_oldest : r_fill[SLOT_W-1:0];
    assign page       = r_in_va[ADDR_W-1:OFFSET_BITS];

    ftlb_cam #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W),
        .SLOT_W  (SLOT_W)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_page    (page),
        .i_frame   (r_in_frame),
        .i_wr_en   (ins),
        .i_wr_slot (slot),
        .o_rsp     (cam_rsp)
    );

    always_comb begin
        frame_wide = {{ADDR_W{1'b0}}, cam_rsp.frame} << OFFSET_BITS;
        n_pa       = frame_wide[ADDR_W-1:0]
                   | {{PAGE_W{1'b0}}, r_in_va[OFFSET_BITS-1:0]};
        n_lookups  = r_lookups;
        n_misses   = r_misses;
        if (r_in_mode == MODE_LOOKUP) begin
            n_lookups = (r_lookups == '1) ? r_lookups : r_lookups + CNT_W'(1);
            if (!cam_rsp.hit) begin
                n_misses = (r_misses == '1) ? r_misses : r_misses + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_tready) begin
            r_in_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= i_s_tuser[0];
            r_in_va    <= i_s_tdata[31:0];
            r_in_frame <= i_s_tdata[51:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_oldest  <= '0;
            r_lookups <= '0;
            r_misses  <= '0;
        end else begin
            if (ins) begin
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end else if (r_oldest == SLOT_W'(TLB_ENTRIES - 1)) begin
                    r_oldest <= '0;
                end else begin
                    r_oldest <= r_oldest + SLOT_W'(1);
                end
            end
            if (look) begin
                r_lookups <= n_lookups;
                r_misses  <= n_misses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hit <= look && cam_rsp.hit;
            r_out_pa  <= (look && cam_rsp.hit) ? n_pa : '0;
            r_out_lc  <= n_lookups;
            r_out_mc  <= n_misses;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_mc, r_out_lc, r_out_pa};
    assign o_m_tuser  = r_out_hit;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TLB_ENTRIES))
        else $error("fill level beyond entry count");

    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (r_oldest == '0))
        else $error("victim pointer moved before the buffer filled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready) |=> ($stable(r_lookups) && $stable(r_fill)))
        else $error("state advanced while result stalled");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_hit) |-> (r_out_lc != '0))
        else $error("hit reported without a counted lookup");

endmodule

### verif/fifo_translation_lookaside_buffer_checker.sv
// ----------------------------------------------------------------------------
// fifo_translation_lookaside_buffer_checker
// Watches both stream channels of the TLB and keeps a private copy of its
// slots, fill level, eviction pointer and saturating counters. Every accepted
// request is translated into the result it must produce. Every accepted
// result is compared field by field against the oldest pending translation.
// ----------------------------------------------------------------------------
module fifo_translation_lookaside_buffer_checker
    import ftlb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,   // virt_addr[31:0], phys_frame[51:32], zero pad
    input  logic [0:0]  i_s_tuser,   // mode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // phys_addr[31:0], lookup_count[63:32], miss_count[95:64]
    input  logic [0:0]  i_m_tuser,   // hit[0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hit_count
);

    localparam int PAGE_SHIFT = $clog2(DEF_PAGE_BYTES);
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] phys_addr;
        logic [CNT_W-1:0]  lookups;
        logic [CNT_W-1:0]  misses;
    } t_translation;

    logic               slot_valid [DEF_TLB_ENTRIES];
    logic [PAGE_W-1:0]  slot_page  [DEF_TLB_ENTRIES];
    logic [FRAME_W-1:0] slot_frame [DEF_TLB_ENTRIES];
    int unsigned        slots_used;
    int unsigned        victim_slot;
    logic [CNT_W-1:0]   lookup_tally;
    logic [CNT_W-1:0]   miss_tally;

    t_translation       pending_translations [$];
    t_translation       observed;
    t_translation       wanted;
    int                 mismatches;
    int                 hits;

    function automatic t_translation translate_request(input logic mode,
                                                       input logic [ADDR_W-1:0] va,
                                                       input logic [FRAME_W-1:0] frame);
        t_translation      r;
        int unsigned       slot;
        int unsigned       k;
        logic [PAGE_W-1:0] page;
        page = va[ADDR_W-1:PAGE_SHIFT];
        r = '0;
        if (mode == MODE_INSERT) begin
            if (slots_used < DEF_TLB_ENTRIES) begin
                slot = slots_used;
                slots_used++;
            end else begin
                slot = victim_slot;
                victim_slot = (victim_slot + 1) % DEF_TLB_ENTRIES;
            end
            slot_valid[slot] = 1'b1;
            slot_page[slot]  = page;
            slot_frame[slot] = frame;
        end else begin
            // scan newest to oldest; first match wins
            for (k = 0; k < slots_used && !r.hit; k++) begin
                slot = (victim_slot + slots_used - 1 - k) % DEF_TLB_ENTRIES;
                if (slot_valid[slot] && slot_page[slot] == page) begin
                    r.hit = 1'b1;
                    r.phys_addr = ADDR_W'({slot_frame[slot], va[PAGE_SHIFT-1:0]});
                end
            end
            if (lookup_tally != CNT_MAX) lookup_tally++;
            if (!r.hit && miss_tally != CNT_MAX) miss_tally++;
        end
        r.lookups = lookup_tally;
        r.misses  = miss_tally;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEF_TLB_ENTRIES; i++) slot_valid[i] = 1'b0;
            slots_used   = 0;
            victim_slot  = 0;
            lookup_tally = '0;
            miss_tally   = '0;
            pending_translations.delete();
            mismatches   = 0;
            hits         = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
            o_hit_count  <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                pending_translations.push_back(
                    translate_request(i_s_tuser[0], i_s_tdata[31:0], i_s_tdata[51:32]));
            end
            if (i_m_tvalid && i_m_tready) begin
                observed = {i_m_tuser[0], i_m_tdata[31:0], i_m_tdata[63:32], i_m_tdata[95:64]};
                if (pending_translations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: hit %0b phys_addr %08h lookups %0d misses %0d",
                                 observed.hit, observed.phys_addr, observed.lookups,
                                 observed.misses);
                end else begin
                    wanted = pending_translations.pop_front();
                    if (observed.hit !== wanted.hit || observed.phys_addr !== wanted.phys_addr ||
                        observed.lookups !== wanted.lookups ||
                        observed.misses !== wanted.misses) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: hit exp %0b got %0b, phys_addr exp %08h got %08h",
                                     wanted.hit, observed.hit, wanted.phys_addr,
                                     observed.phys_addr);
                            $display("          lookups exp %0d got %0d, misses exp %0d got %0d",
                                     wanted.lookups, observed.lookups, wanted.misses,
                                     observed.misses);
                        end
                    end
                    if (wanted.hit) hits++;
                end
            end
            o_fail_count <= mismatches;
            o_pending    <= pending_translations.size();
            o_hit_count  <= hits;
        end
    end

endmodule

### verif/fifo_translation_lookaside_buffer_test.sv
// ----------------------------------------------------------------------------
// fifo_translation_lookaside_buffer_test
// Drives lookup and insert requests into the TLB: a directed opening on the
// empty buffer, address extremes and duplicate pages, then random phases over
// page pools smaller and larger than the buffer so that hits, misses and FIFO
// evictions all occur. Both channels idle at random; one phase holds the
// result side off long enough to stall the request side. Checking is done by
// the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module fifo_translation_lookaside_buffer_test;
    import ftlb_pkg::*;

    localparam int PAGE_SHIFT      = $clog2(DEF_PAGE_BYTES);
    localparam int PAGE_W          = ADDR_W - PAGE_SHIFT;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int PHASES          = 4;
    localparam int POOL_MAX        = 128;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} t_idle_style;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata  = '0;    // virt_addr[31:0], phys_frame[51:32], zero pad
    logic [0:0]  i_s_tuser  = '0;    // mode[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;          // phys_addr[31:0], lookup_count[63:32], miss_count[95:64]
    logic [0:0]  o_m_tuser;          // hit[0]

    int          fail_count;
    int          pending_count;
    int          hit_count;

    t_idle_style       idle_style = IDLE_FULL;
    bit                hold_sink  = 1'b0;
    logic [PAGE_W-1:0] page_pool [POOL_MAX];
    int                pool_size  = 16;
    int                inserts_sent = 0;
    int                lookups_sent = 0;

    fifo_translation_lookaside_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    fifo_translation_lookaside_buffer_checker translation_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_hit_count  (hit_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        case (idle_style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, 18);
        endcase
    endfunction

    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] va,
                                input logic [FRAME_W-1:0] frame);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= 56'({frame, va});
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (mode == MODE_INSERT) inserts_sent++;
        else lookups_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // result side: idle per result, honor a long hold request
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 pending_count);
        $display("fifo_translation_lookaside_buffer_test NOT OK");
        $finish;
    end

    initial begin
        int                 phase;
        int                 n;
        logic               mode;
        logic [PAGE_W-1:0]  page;
        logic [ADDR_W-1:0]  va;

        page_pool[0] = '0;
        page_pool[1] = '1;
        for (n = 2; n < POOL_MAX; n++) page_pool[n] = PAGE_W'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty buffer: lookups miss, frame field ignored
        send_request(MODE_LOOKUP, 32'h0000_0000, 20'hFFFFF);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 20'h00000);
        // address and frame extremes
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 20'hFFFFF);
        send_request(MODE_INSERT, 32'h0000_0000, 20'h00000);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 20'h00000);
        send_request(MODE_LOOKUP, 32'h0000_0FFF, 20'hFFFFF);
        send_request(MODE_LOOKUP, 32'hFFFF_F000, 20'h12345);
        // duplicate page: newest copy must win
        send_request(MODE_INSERT, 32'h1234_5000, 20'h00001);
        send_request(MODE_INSERT, 32'h1234_5FFF, 20'hABCDE);
        send_request(MODE_LOOKUP, 32'h1234_5678, 20'h00000);
        send_request(MODE_LOOKUP, 32'h5555_5555, 20'hAAAAA);
        send_request(MODE_INSERT, 32'hAAAA_AAAA, 20'h55555);
        send_request(MODE_LOOKUP, 32'hAAAA_A555, 20'h00000);
        send_request(MODE_LOOKUP, 32'h1234_5000, 20'hFFFFF);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin idle_style = IDLE_FULL;  pool_size = 24;  end
                1: begin idle_style = IDLE_NONE;  pool_size = 100; hold_sink = 1'b1; end
                2: begin idle_style = IDLE_LIGHT; pool_size = 64;  end
                default: begin idle_style = IDLE_FULL; pool_size = POOL_MAX; end
            endcase
            for (n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
                mode = ($urandom_range(0, 99) < 40) ? MODE_INSERT : MODE_LOOKUP;
                if ($urandom_range(0, 9) < 8) page = page_pool[$urandom_range(0, pool_size - 1)];
                else page = PAGE_W'($urandom);
                va = ADDR_W'({page, PAGE_SHIFT'($urandom)});
                send_request(mode, va, FRAME_W'($urandom));
            end
            // pause the request side until every result is back
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d requests: %0d inserts, %0d lookups, %0d hits", 
                 inserts_sent + lookups_sent, inserts_sent, lookups_sent, hit_count);
        $display("page pools up to %0d pages over %0d slots, FIFO eviction and stalls on both sides",
                 POOL_MAX, DEF_TLB_ENTRIES);
        if (fail_count == 0 && pending_count == 0) begin
            $display("fifo_translation_lookaside_buffer_test OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending_count);
            $display("fifo_translation_lookaside_buffer_test NOT OK");
        end
        $finish;
    end

endmodule
